/* rtl/core/indexed_list_engine_assert.svh */
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// check cons in the same cycle as ante
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ile_pkg.sv */
package ile_pkg;

    localparam int ILE_CAPACITY = 64;
    localparam int LEN_W        = 7;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int FUNC_W       = 3;

    localparam logic [DATA_W-1:0] RD_FAIL = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_READ   = 3'd2,
        FN_WRITE  = 3'd3,
        FN_DELETE = 3'd4,
        FN_SIZE   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_WR   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [LEN_W-1:0]  idx;
        logic              load;
        logic              rd_en;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

/* rtl/core/ile_cell.sv */
module ile_cell
    import ile_pkg::*;
(
    input  logic              clk,
    input  logic [LEN_W-1:0]  index,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic              hit;

    assign hit = (cmd.idx == index);

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            OP_INS:
            begin
                if (index > cmd.idx)
                begin
                    data_next = left;
                end
                else if (hit)
                begin
                    data_next = cmd.value;
                end
            end
            OP_DEL:
            begin
                if (index >= cmd.idx)
                begin
                    data_next = right;
                end
            end
            OP_WR:
            begin
                if (hit)
                begin
                    data_next = cmd.value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    assign rd_next = (cmd.rd_en && hit) ? data_reg : '0;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmd.load)
        begin
            rd_reg <= rd_next;
        end
    end

    assign data    = data_reg;
    assign rd_data = rd_reg;

endmodule

/* rtl/core/indexed_list_engine.sv */
// Ordered list of up to CAPACITY signed 32-bit entries with an entry count.
// Request channel: in_valid / in_stall with func, position and value.
// Result channel: out_valid / out_stall with read_value, length and status.
// A request is taken when in_valid is high and in_stall is low; every
// request yields exactly one result, in request order.
// A request passes through the middle stage and then the output register
// before out_valid rises and the result can be taken.
// Throughput: one request per cycle while out_stall is low; insert and delete
// shift the whole row of entry cells by one place in the cycle the request is
// taken, so no operation takes longer than any other.
// A read picks its entry in the cells and gathers it into the result when
// the middle stage advances; the output register decouples the two sides.
// When out_stall holds a result, one more request may wait in the middle
// stage; after that in_stall rises until the result is taken.
// Reset empties the list (count zero) and drops any pending result; entry
// contents are not cleared, since nothing at or past the count is ever read.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] read_value,
    output logic [LEN_W-1:0]         length,
    output logic [1:0]               status
);

    `include "indexed_list_engine_assert.svh"

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];
    cell_cmd_t         cmd;

    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [LEN_W-1:0]  s1_len_reg;
    status_t           s1_status_reg;
    logic              s1_fail_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_rd_reg;
    logic [LEN_W-1:0]  out_len_reg;
    status_t           out_status_reg;

    logic              acc;
    logic              s1_adv;
    logic              neg;
    logic [LEN_W-1:0]  pos;
    logic              in_range;
    logic              full;
    status_t           st;
    logic              fail;
    logic [DATA_W-1:0] rd_or;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign acc      = in_valid && !in_stall;

    assign neg      = position[POS_W-1];
    assign pos      = position[LEN_W-1:0];
    assign in_range = !neg && (pos < count_reg);
    assign full     = (count_reg >= CAP_LEN);

    always_comb
    begin
        cmd.op     = OP_HOLD;
        cmd.idx    = pos;
        cmd.load   = acc;
        cmd.rd_en  = 1'b0;
        cmd.value  = value;
        count_next = count_reg;
        st         = ST_OK;
        fail       = 1'b0;
        if (acc)
        begin
            unique case (func_t'(func))
                FN_APPEND:
                begin
                    if (full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = OP_INS;
                        cmd.idx    = count_reg;
                        count_next = count_reg + LEN_W'(1);
                    end
                end
                FN_INSERT:
                begin
                    if (neg)
                    begin
                        st = ST_BAD;
                    end
                    else if (full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = OP_INS;
                        cmd.idx    = in_range ? pos : count_reg;
                        count_next = count_reg + LEN_W'(1);
                    end
                end
                FN_READ:
                begin
                    if (in_range)
                    begin
                        cmd.rd_en = 1'b1;
                    end
                    else
                    begin
                        st   = ST_BAD;
                        fail = 1'b1;
                    end
                end
                FN_WRITE:
                begin
                    if (in_range)
                    begin
                        cmd.op = OP_WR;
                    end
                    else
                    begin
                        st = ST_BAD;
                    end
                end
                FN_DELETE:
                begin
                    if (in_range)
                    begin
                        cmd.op     = OP_DEL;
                        count_next = count_reg - LEN_W'(1);
                    end
                    else
                    begin
                        st = ST_BAD;
                    end
                end
                default:
                begin
                    st = ST_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        ile_cell u_cell (
            .clk     (clk),
            .index   (LEN_W'(i)),
            .cmd     (cmd),
            .left    (left_w),
            .right   (right_w),
            .data    (cell_data[i]),
            .rd_data (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    assign s1_valid_next  = acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_len_reg    <= count_next;
            s1_status_reg <= st;
            s1_fail_reg   <= fail;
        end
        if (s1_adv)
        begin
            out_rd_reg     <= s1_fail_reg ? RD_FAIL : rd_or;
            out_len_reg    <= s1_len_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_rd_reg;
    assign length     = out_len_reg;
    assign status     = out_status_reg;

    `ILE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_LEN, "entry count past capacity")
    `ILE_ASSERT_NOW(a_full_len, out_valid_reg && out_status_reg == ST_FULL,
                    out_len_reg == CAP_LEN, "full status with list not full")
    `ILE_ASSERT_NEXT(a_append_grow, acc && func == FN_APPEND && count_reg < CAP_LEN,
                     count_reg == $past(count_reg) + LEN_W'(1), "append did not grow list")
    `ILE_ASSERT_NOW(a_fail_bad, s1_valid_reg && s1_fail_reg,
                    s1_status_reg == ST_BAD, "failed read without bad status")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ile_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;
    localparam logic signed [DATA_W-1:0] DMAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] DMIN = 32'sh80000000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_CHURN } mix_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd;
        logic [LEN_W-1:0]         len;
        status_t                  st;
    } list_result_t;

    typedef struct {
        logic [FUNC_W-1:0]        fn;
        logic signed [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] val;
        bit                       rand_val;
        int                       reps;
        bit                       typed;
        logic signed [DATA_W-1:0] e_rd;
        logic [LEN_W-1:0]         e_len;
        status_t                  e_st;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
    logic [1:0]               status;

    logic signed [DATA_W-1:0] shadow_list [ILE_CAPACITY];
    int                       shadow_len;
    list_result_t             expected_q [$];

    int  mismatch_count;
    int  results_seen;
    int  requests_sent;
    int  full_refusals;
    int  bad_answers;
    int  peak_len;
    int  cycle_count;
    bit  hold_request;

    plan_row_t plan_tbl [29];

    indexed_list_engine u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic list_result_t apply_request(input logic [FUNC_W-1:0] fn,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t res;
        bit  neg;
        int  idx;
        int  at;
        bit  in_range;
        bit  full;
        neg      = pos[POS_W-1];
        idx      = int'(pos[POS_W-2:0]);
        in_range = !neg && (idx < shadow_len);
        full     = shadow_len >= ILE_CAPACITY;
        res.rd   = '0;
        res.st   = ST_OK;
        case (fn)
            FN_APPEND, FN_INSERT:
            begin
                if (fn == FN_INSERT && neg)
                    res.st = ST_BAD;
                else if (full)
                    res.st = ST_FULL;
                else
                begin
                    at = (fn == FN_INSERT && in_range) ? idx : shadow_len;
                    for (int i = shadow_len; i > at; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[at] = val;
                    shadow_len++;
                end
            end
            FN_READ:
            begin
                if (in_range)
                    res.rd = shadow_list[idx];
                else
                begin
                    res.rd = RD_FAIL;
                    res.st = ST_BAD;
                end
            end
            FN_WRITE:
            begin
                if (in_range)
                    shadow_list[idx] = val;
                else
                    res.st = ST_BAD;
            end
            FN_DELETE:
            begin
                if (in_range)
                begin
                    for (int i = idx; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
                else
                    res.st = ST_BAD;
            end
            default:
            begin
            end
        endcase
        res.len = LEN_W'(shadow_len);
        if (res.st == ST_FULL)
            full_refusals++;
        if (res.st == ST_BAD)
            bad_answers++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return res;
    endfunction

    function automatic int idle_span();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(input mix_t mix);
        int r;
        int cut [5];
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   cut = '{35, 65, 78, 88, 93};
            MIX_SHRINK: cut = '{5, 15, 30, 40, 90};
            default:    cut = '{18, 36, 56, 71, 91};
        endcase
        if (r < cut[0]) return FN_APPEND;
        if (r < cut[1]) return FN_INSERT;
        if (r < cut[2]) return FN_READ;
        if (r < cut[3]) return FN_WRITE;
        if (r < cut[4]) return FN_DELETE;
        case ($urandom_range(0, 2))
            0:       return FN_SIZE;
            1:       return FN_SPARE6;
            default: return FN_SPARE7;
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return POS_W'($urandom_range(128, 255));
        if (r == 1)
            return POS_W'($urandom_range(0, 127));
        if (r <= 3 || shadow_len == 0)
            return POS_W'(shadow_len);
        return POS_W'($urandom_range(0, shadow_len - 1));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return DMAX;
            1:       return DMIN;
            2:       return -32'sd1;
            3:       return '0;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // hold the request until taken, then log what it should produce
    task automatic offer(input logic [FUNC_W-1:0] fn, input logic signed [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val, input bit typed,
                         input list_result_t typed_res);
        list_result_t res;
        in_valid <= 1'b1;
        func     <= fn;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = apply_request(fn, pos, val);
        expected_q.push_back(typed ? typed_res : res);
        requests_sent++;
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic flag_mismatch(input string field, input logic signed [DATA_W-1:0] want,
                                 input logic signed [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on result %0d: %s expected %0d, got %0d",
                     results_seen, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result with no request outstanding: read_value %0d length %0d",
                             read_value, length);
            end
            else
            begin
                want = expected_q.pop_front();
                if (read_value !== want.rd)
                    flag_mismatch("read_value", want.rd, read_value);
                if (length !== want.len)
                    flag_mismatch("length", DATA_W'(want.len), DATA_W'(length));
                if (status !== want.st)
                    flag_mismatch("status", DATA_W'(want.st), DATA_W'(status));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : result_drain
        int  stall_left;
        int  spell;
        bit  calm;
        bit  hold_served;
        stall_left  = 0;
        spell       = 0;
        calm        = 1'b0;
        hold_served = 1'b0;
        out_stall  <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                out_stall  <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall  <= 1'b0;
            end
            else
            begin
                if (spell == 0)
                begin
                    calm  = ($urandom_range(0, 3) == 0);
                    spell = $urandom_range(50, 200);
                end
                spell--;
                if (stall_left > 0)
                    stall_left--;
                else if (!calm && $urandom_range(0, 4) == 0)
                    stall_left = idle_span();
                out_stall <= (stall_left > 0);
            end
        end
    end

    initial
    begin : request_feed
        list_result_t              typed_res;
        logic signed [DATA_W-1:0]  val;
        mix_t                      mix;
        int                        span;
        bit                        burst;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= FN_SIZE;
        position     <= '0;
        value        <= '0;
        hold_request <= 1'b0;
        shadow_len   = 0;
        mismatch_count = 0;
        results_seen   = 0;
        requests_sent  = 0;
        full_refusals  = 0;
        bad_answers    = 0;
        peak_len       = 0;
        cycle_count    = 0;

        plan_tbl = '{
            '{FN_SIZE,     8'sd0,    32'sd0,  0, 1,  1, 32'sd0,  7'd0,  ST_OK},
            '{FN_READ,     8'sd0,    32'sd0,  0, 1,  1, RD_FAIL, 7'd0,  ST_BAD},
            '{FN_DELETE,   8'sd0,    32'sd0,  0, 1,  1, 32'sd0,  7'd0,  ST_BAD},
            '{FN_WRITE,    8'sd0,    32'sd9,  0, 1,  1, 32'sd0,  7'd0,  ST_BAD},
            '{FN_INSERT,   -8'sd1,   32'sd9,  0, 1,  1, 32'sd0,  7'd0,  ST_BAD},
            '{FN_APPEND,   8'sd0,    DMAX,    0, 1,  1, 32'sd0,  7'd1,  ST_OK},
            '{FN_APPEND,   -8'sd128, DMIN,    0, 1,  1, 32'sd0,  7'd2,  ST_OK},
            '{FN_INSERT,   8'sd0,    32'sd5,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_INSERT,   8'sd127,  -32'sd1, 0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_READ,     8'sd0,    32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_READ,     8'sd127,  32'sd0,  0, 1,  1, RD_FAIL, 7'd4,  ST_BAD},
            '{FN_READ,     -8'sd128, 32'sd0,  0, 1,  1, RD_FAIL, 7'd4,  ST_BAD},
            '{FN_WRITE,    8'sd1,    32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_WRITE,    8'sd4,    32'sd3,  0, 1,  1, 32'sd0,  7'd4,  ST_BAD},
            '{FN_DELETE,   8'sd0,    32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_DELETE,   -8'sd1,   32'sd0,  0, 1,  1, 32'sd0,  7'd3,  ST_BAD},
            '{FN_SPARE6,   8'sd5,    32'sd77, 0, 1,  1, 32'sd0,  7'd3,  ST_OK},
            '{FN_SPARE7,   -8'sd1,   -32'sd1, 0, 1,  1, 32'sd0,  7'd3,  ST_OK},
            '{FN_SIZE,     -8'sd1,   -32'sd1, 0, 1,  1, 32'sd0,  7'd3,  ST_OK},
            '{FN_READ,     8'sd2,    32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_APPEND,   8'sd0,    32'sd0,  1, 61, 0, 32'sd0,  7'd0,  ST_OK},
            '{FN_APPEND,   8'sd0,    32'sd7,  0, 1,  1, 32'sd0,  7'd64, ST_FULL},
            '{FN_INSERT,   8'sd0,    32'sd7,  0, 1,  1, 32'sd0,  7'd64, ST_FULL},
            '{FN_INSERT,   8'sd127,  32'sd7,  0, 1,  1, 32'sd0,  7'd64, ST_FULL},
            '{FN_INSERT,   -8'sd1,   32'sd7,  0, 1,  1, 32'sd0,  7'd64, ST_BAD},
            '{FN_READ,     8'sd63,   32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_READ,     8'sd64,   32'sd0,  0, 1,  1, RD_FAIL, 7'd64, ST_BAD},
            '{FN_DELETE,   8'sd63,   32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK},
            '{FN_DELETE,   8'sd0,    32'sd0,  0, 1,  0, 32'sd0,  7'd0,  ST_OK}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_tbl[i])
        begin
            typed_res = '{rd: plan_tbl[i].e_rd, len: plan_tbl[i].e_len, st: plan_tbl[i].e_st};
            for (int k = 0; k < plan_tbl[i].reps; k++)
            begin
                val = plan_tbl[i].rand_val ? DATA_W'($urandom()) : plan_tbl[i].val;
                offer(plan_tbl[i].fn, plan_tbl[i].pos, val, plan_tbl[i].typed, typed_res);
                pause_sender(($urandom_range(0, 1) == 0) ? 0 : idle_span());
            end
        end

        mix   = MIX_EVEN;
        burst = 1'b0;
        span  = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (span == 0)
            begin
                mix   = mix_t'($urandom_range(0, 3));
                burst = ($urandom_range(0, 3) == 0);
                span  = $urandom_range(48, 160);
            end
            span--;
            if (n == 400)
                hold_request <= 1'b1;
            // drain everything before resuming
            if (n == 800)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
            end
            offer(pick_func(mix), pick_position(), pick_value(), 1'b0, '0);
            if (!burst && $urandom_range(0, 1) == 0)
                pause_sender(idle_span());
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_seen, mismatch_count);
        $display("list reached %0d entries; %0d refused as full, %0d bad-index answers",
                 peak_len, full_refusals, bad_answers);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
